// ===== src/mfs_pkg.sv =====
// shared constants and command/status types for the multiplicative fusion stretch block
// no dependencies
package mfs_pkg;

	localparam int PIX_W    = 8;
	localparam int PROD_W   = 2 * PIX_W;
	localparam int CHANNELS = 3;
	localparam int REM_W    = PROD_W + PIX_W;
	localparam int DVS_W    = PROD_W + PIX_W - 1;
	localparam int STEPS    = PIX_W;
	localparam int STEP_W   = $clog2(STEPS);

	localparam logic [PROD_W-1:0] PROD_TOP = PROD_W'(65025);
	localparam logic [PIX_W-1:0]  OUT_TOP  = PIX_W'(255);

	localparam logic MODE_GATHER = 1'b0;
	localparam logic MODE_EMIT   = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic mult;
		logic stat;
		logic prep;
		logic num;
		logic step;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mode;
	} sts_t;

endpackage

// ===== src/mfs_datapath.sv =====
// datapath: input word registers, products, min/max statistics, restoring dividers
// depends on mfs_pkg
module mfs_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mfs_pkg::cmd_t             cmd,
	output mfs_pkg::sts_t             sts,
	input  logic                      mode,
	input  logic                      frame_start,
	input  logic [mfs_pkg::PIX_W-1:0] pan,
	input  logic [mfs_pkg::PIX_W-1:0] band_one,
	input  logic [mfs_pkg::PIX_W-1:0] band_two,
	input  logic [mfs_pkg::PIX_W-1:0] band_three,
	output logic [mfs_pkg::PIX_W-1:0] out_one,
	output logic [mfs_pkg::PIX_W-1:0] out_two,
	output logic [mfs_pkg::PIX_W-1:0] out_three
);

	logic                       mode_q;
	logic                       start_q;
	logic [mfs_pkg::PIX_W-1:0]  pan_q;
	logic [mfs_pkg::PIX_W-1:0]  band_q   [mfs_pkg::CHANNELS];
	logic [mfs_pkg::PROD_W-1:0] prod_s1  [mfs_pkg::CHANNELS];
	logic [mfs_pkg::PROD_W-1:0] min_q    [mfs_pkg::CHANNELS];
	logic [mfs_pkg::PROD_W-1:0] max_q    [mfs_pkg::CHANNELS];
	logic                       zero_s2  [mfs_pkg::CHANNELS];
	logic                       top_s2   [mfs_pkg::CHANNELS];
	logic [mfs_pkg::PROD_W-1:0] diff_s2  [mfs_pkg::CHANNELS];
	logic [mfs_pkg::PROD_W-1:0] span_s2  [mfs_pkg::CHANNELS];
	logic [mfs_pkg::REM_W-1:0]  rem_q    [mfs_pkg::CHANNELS];
	logic [mfs_pkg::DVS_W-1:0]  dvs_q    [mfs_pkg::CHANNELS];
	logic [mfs_pkg::PIX_W-1:0]  quo_q    [mfs_pkg::CHANNELS];
	logic [mfs_pkg::PIX_W-1:0]  res_q    [mfs_pkg::CHANNELS];

	assign sts.mode = mode_q;
	assign out_one   = res_q[0];
	assign out_two   = res_q[1];
	assign out_three = res_q[2];

	// input word capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q    <= mode;
			start_q   <= frame_start;
			pan_q     <= pan;
			band_q[0] <= band_one;
			band_q[1] <= band_two;
			band_q[2] <= band_three;
		end
	end

	// products, stretch setup, divide steps, result register
	always_ff @(posedge clk) begin
		for (int c = 0; c < mfs_pkg::CHANNELS; c++) begin
			if (cmd.mult) begin
				prod_s1[c] <= {{mfs_pkg::PIX_W{1'b0}}, pan_q}
					* {{mfs_pkg::PIX_W{1'b0}}, band_q[c]};
			end
			if (cmd.prep) begin
				zero_s2[c] <= (max_q[c] <= min_q[c]) || (prod_s1[c] <= min_q[c]);
				top_s2[c]  <= prod_s1[c] >= max_q[c];
				diff_s2[c] <= prod_s1[c] - min_q[c];
				span_s2[c] <= max_q[c] - min_q[c];
			end
			// numerator is diff*255, divisor starts at span aligned to the top quotient bit
			if (cmd.num) begin
				rem_q[c] <= {diff_s2[c], {mfs_pkg::PIX_W{1'b0}}}
					- {{mfs_pkg::PIX_W{1'b0}}, diff_s2[c]};
				dvs_q[c] <= {span_s2[c], {(mfs_pkg::PIX_W-1){1'b0}}};
				quo_q[c] <= '0;
			end else if (cmd.step) begin
				if (rem_q[c] >= {1'b0, dvs_q[c]}) begin
					rem_q[c] <= rem_q[c] - {1'b0, dvs_q[c]};
					quo_q[c] <= {quo_q[c][mfs_pkg::PIX_W-2:0], 1'b1};
				end else begin
					quo_q[c] <= {quo_q[c][mfs_pkg::PIX_W-2:0], 1'b0};
				end
				dvs_q[c] <= dvs_q[c] >> 1;
			end
			if (cmd.load_out) begin
				if (zero_s2[c]) begin
					res_q[c] <= '0;
				end else if (top_s2[c]) begin
					res_q[c] <= mfs_pkg::OUT_TOP;
				end else begin
					res_q[c] <= quo_q[c];
				end
			end
		end
	end

	// per-channel statistics, frame start restarts them from this pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < mfs_pkg::CHANNELS; c++) begin
				min_q[c] <= mfs_pkg::PROD_TOP;
				max_q[c] <= '0;
			end
		end else if (cmd.stat) begin
			for (int c = 0; c < mfs_pkg::CHANNELS; c++) begin
				if (start_q || prod_s1[c] < min_q[c]) begin
					min_q[c] <= prod_s1[c];
				end
				if (start_q || prod_s1[c] > max_q[c]) begin
					max_q[c] <= prod_s1[c];
				end
			end
		end
	end

endmodule

// ===== src/mfs_ctrl.sv =====
// controller: sequences capture, multiply, statistics or stretch divide, and output word
// depends on mfs_pkg
module mfs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  mfs_pkg::sts_t sts,
	output mfs_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULT,
		ST_STAT,
		ST_PREP,
		ST_NUM,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                     state_q;
	logic [mfs_pkg::STEP_W-1:0] step_q;
	logic                       out_valid_q;
	logic                       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.load_in  = (state_q == ST_IDLE) && in_valid;
		cmd.mult     = (state_q == ST_MULT);
		cmd.stat     = (state_q == ST_STAT);
		cmd.prep     = (state_q == ST_PREP);
		cmd.num      = (state_q == ST_NUM);
		cmd.step     = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

	// state, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// set when a word is loaded, held until it is taken
			out_valid_q <= ((state_q == ST_DONE) && out_free) || (out_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MULT;
					end
				end
				ST_MULT: begin
					if (sts.mode == mfs_pkg::MODE_GATHER) begin
						state_q <= ST_STAT;
					end else begin
						state_q <= ST_PREP;
					end
				end
				ST_STAT: begin
					state_q <= ST_IDLE;
				end
				ST_PREP: begin
					state_q <= ST_NUM;
				end
				ST_NUM: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + mfs_pkg::STEP_W'(1);
					if (step_q == mfs_pkg::STEP_W'(mfs_pkg::STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/multiplicative_fusion_stretch.sv =====
// top level of the multiplicative fusion stretch block
// depends on mfs_pkg, mfs_ctrl and mfs_datapath
//
// Each input word carries a pan byte and three band bytes; the block forms the three
// products pan*band. A gather word (mode 0) folds the products into per-channel min/max
// statistics (frame_start restarts them) and gives no output word; it occupies the block
// through its multiply and statistics states. An emit word (mode 1) gives one output word
// with each channel stretched to floor((p-min)*255/(max-min)), 0 for a flat or empty
// channel, saturating below min and above max; it passes the multiply, setup and numerator
// states and the eight-step restoring divider that all three channels run in parallel, and
// the next input word can be taken in the cycle after its output register load. A finished
// word waits in the output register while the next input word is taken; an emit word that
// finishes while the previous one still waits holds until out_ready frees the register.
module multiplicative_fusion_stretch (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      mode,
	input  logic                      frame_start,
	input  logic [mfs_pkg::PIX_W-1:0] pan,
	input  logic [mfs_pkg::PIX_W-1:0] band_one,
	input  logic [mfs_pkg::PIX_W-1:0] band_two,
	input  logic [mfs_pkg::PIX_W-1:0] band_three,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [mfs_pkg::PIX_W-1:0] out_one,
	output logic [mfs_pkg::PIX_W-1:0] out_two,
	output logic [mfs_pkg::PIX_W-1:0] out_three
);

	mfs_pkg::cmd_t cmd;
	mfs_pkg::sts_t sts;

	// sequencing
	mfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic and statistics
	mfs_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.frame_start (frame_start),
		.pan         (pan),
		.band_one    (band_one),
		.band_two    (band_two),
		.band_three  (band_three),
		.out_one     (out_one),
		.out_two     (out_two),
		.out_three   (out_three)
	);

endmodule

// ===== test/tb_top.sv =====
// testbench for multiplicative_fusion_stretch: gather/emit frames with random gaps and stalls
// checks every output word against a scoreboard that tracks per-channel min/max statistics
// depends on mfs_pkg and the multiplicative_fusion_stretch rtl
module tb_top;

	typedef struct packed {
		logic [mfs_pkg::PIX_W-1:0] one;
		logic [mfs_pkg::PIX_W-1:0] two;
		logic [mfs_pkg::PIX_W-1:0] three;
	} stretch_word_t;

	// predicts stretched words from accepted pixels and compares them with the output
	class stretch_scoreboard;
		logic [mfs_pkg::PROD_W-1:0] lo_prod [mfs_pkg::CHANNELS];
		logic [mfs_pkg::PROD_W-1:0] hi_prod [mfs_pkg::CHANNELS];
		stretch_word_t              pending_words [$];
		int                         errors;

		function new();
			errors = 0;
			clear_stats();
		endfunction

		function void clear_stats();
			for (int c = 0; c < mfs_pkg::CHANNELS; c++) begin
				lo_prod[c] = mfs_pkg::PROD_TOP;
				hi_prod[c] = '0;
			end
		endfunction

		function logic [mfs_pkg::PIX_W-1:0] stretch_chan(logic [mfs_pkg::PROD_W-1:0] p,
				logic [mfs_pkg::PROD_W-1:0] lo, logic [mfs_pkg::PROD_W-1:0] hi);
			logic [31:0] num;
			logic [31:0] span;
			// flat or empty statistics, then saturation on either side
			if (hi <= lo)
				return '0;
			if (p <= lo)
				return '0;
			if (p >= hi)
				return mfs_pkg::OUT_TOP;
			num  = 32'(p - lo) * 32'(mfs_pkg::OUT_TOP);
			span = 32'(hi - lo);
			return mfs_pkg::PIX_W'(num / span);
		endfunction

		function void note_pixel(logic m, logic fs, logic [mfs_pkg::PIX_W-1:0] p,
				logic [mfs_pkg::PIX_W-1:0] b1, logic [mfs_pkg::PIX_W-1:0] b2,
				logic [mfs_pkg::PIX_W-1:0] b3);
			logic [mfs_pkg::PROD_W-1:0] prod [mfs_pkg::CHANNELS];
			stretch_word_t              w;
			prod[0] = mfs_pkg::PROD_W'(p) * mfs_pkg::PROD_W'(b1);
			prod[1] = mfs_pkg::PROD_W'(p) * mfs_pkg::PROD_W'(b2);
			prod[2] = mfs_pkg::PROD_W'(p) * mfs_pkg::PROD_W'(b3);
			if (m == mfs_pkg::MODE_GATHER) begin
				if (fs)
					clear_stats();
				// min and max are updated independently
				for (int c = 0; c < mfs_pkg::CHANNELS; c++) begin
					if (prod[c] < lo_prod[c])
						lo_prod[c] = prod[c];
					if (prod[c] > hi_prod[c])
						hi_prod[c] = prod[c];
				end
			end else begin
				w.one   = stretch_chan(prod[0], lo_prod[0], hi_prod[0]);
				w.two   = stretch_chan(prod[1], lo_prod[1], hi_prod[1]);
				w.three = stretch_chan(prod[2], lo_prod[2], hi_prod[2]);
				pending_words.push_back(w);
			end
		endfunction

		function void check_word(logic [mfs_pkg::PIX_W-1:0] o1, logic [mfs_pkg::PIX_W-1:0] o2,
				logic [mfs_pkg::PIX_W-1:0] o3);
			stretch_word_t w;
			if (pending_words.size() == 0) begin
				$error("output word %0d/%0d/%0d with no word expected", o1, o2, o3);
				errors++;
				return;
			end
			w = pending_words.pop_front();
			if (o1 !== w.one) begin
				$error("out_one: expected %0d, got %0d", w.one, o1);
				errors++;
			end
			if (o2 !== w.two) begin
				$error("out_two: expected %0d, got %0d", w.two, o2);
				errors++;
			end
			if (o3 !== w.three) begin
				$error("out_three: expected %0d, got %0d", w.three, o3);
				errors++;
			end
		endfunction

		function int pending();
			return pending_words.size();
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic                      mode;
	logic                      frame_start;
	logic [mfs_pkg::PIX_W-1:0] pan;
	logic [mfs_pkg::PIX_W-1:0] band_one;
	logic [mfs_pkg::PIX_W-1:0] band_two;
	logic [mfs_pkg::PIX_W-1:0] band_three;
	logic                      out_valid;
	logic                      out_ready;
	logic [mfs_pkg::PIX_W-1:0] out_one;
	logic [mfs_pkg::PIX_W-1:0] out_two;
	logic [mfs_pkg::PIX_W-1:0] out_three;

	stretch_scoreboard sb = new();
	bit                steady = 1'b0;
	int unsigned       words_sent = 0;
	int unsigned       stall_left = 0;

	multiplicative_fusion_stretch dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.frame_start(frame_start),
		.pan        (pan),
		.band_one   (band_one),
		.band_two   (band_two),
		.band_three (band_three),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_one    (out_one),
		.out_two    (out_two),
		.out_three  (out_three)
	);

	always #5 clk = ~clk;

	// mostly short gaps, a few long ones, none during steady stretches
	function int unsigned pick_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// extremes come up often, the rest uniform
	function logic [mfs_pkg::PIX_W-1:0] pick_byte();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return mfs_pkg::PIX_W'($urandom_range(0, 255));
	endfunction

	// output side: accept words and stall at random
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_word(out_one, out_two, out_three);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// drive one input word and wait for it to be taken
	task automatic send_pixel(input logic m, input logic fs,
			input logic [mfs_pkg::PIX_W-1:0] p, input logic [mfs_pkg::PIX_W-1:0] b1,
			input logic [mfs_pkg::PIX_W-1:0] b2, input logic [mfs_pkg::PIX_W-1:0] b3);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		frame_start <= fs;
		pan         <= p;
		band_one    <= b1;
		band_two    <= b2;
		band_three  <= b3;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_pixel(m, fs, p, b1, b2, b3);
		words_sent++;
	endtask

	// hold the input side until every expected word is out
	task automatic drain_outputs();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// one frame: gather pass then emit pass, or a burst of noise
	task automatic run_frame(input bit force_drain);
		int unsigned               kind;
		int unsigned               n_gather;
		int unsigned               n_emit;
		bit                        pan_fixed;
		bit                        band_fixed [mfs_pkg::CHANNELS];
		logic [mfs_pkg::PIX_W-1:0] pan_val;
		logic [mfs_pkg::PIX_W-1:0] band_val [mfs_pkg::CHANNELS];
		logic [mfs_pkg::PIX_W-1:0] p;
		logic [mfs_pkg::PIX_W-1:0] b [mfs_pkg::CHANNELS];
		kind      = $urandom_range(0, 9);
		steady    = ($urandom_range(0, 5) == 0);
		n_gather  = $urandom_range(1, 8);
		n_emit    = $urandom_range(1, 10);
		pan_fixed = ($urandom_range(0, 4) == 0);
		pan_val   = pick_byte();
		for (int c = 0; c < mfs_pkg::CHANNELS; c++) begin
			band_fixed[c] = ($urandom_range(0, 4) == 0);
			band_val[c]   = pick_byte();
		end
		if (kind == 8) begin
			// noise: anything goes
			for (int i = 0; i < n_emit; i++)
				send_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_byte(),
					pick_byte(), pick_byte(), pick_byte());
			return;
		end
		// gather pass; kind 9 continues the old statistics or skips gathering
		if (kind != 9 || $urandom_range(0, 1) == 0) begin
			for (int i = 0; i < n_gather; i++) begin
				p = pan_fixed ? pan_val : pick_byte();
				for (int c = 0; c < mfs_pkg::CHANNELS; c++)
					b[c] = band_fixed[c] ? band_val[c] : pick_byte();
				send_pixel(mfs_pkg::MODE_GATHER, (i == 0 && kind != 9), p, b[0], b[1], b[2]);
			end
		end
		if (force_drain || $urandom_range(0, 7) == 0)
			drain_outputs();
		// emit pass; frame_start here must have no effect
		for (int i = 0; i < n_emit; i++) begin
			p = pan_fixed ? pan_val : pick_byte();
			for (int c = 0; c < mfs_pkg::CHANNELS; c++)
				b[c] = band_fixed[c] ? band_val[c] : pick_byte();
			send_pixel(mfs_pkg::MODE_EMIT, 1'($urandom_range(0, 1)), p, b[0], b[1], b[2]);
		end
	endtask

	// stimulus and end of run
	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		mode        <= mfs_pkg::MODE_GATHER;
		frame_start <= 1'b0;
		pan         <= '0;
		band_one    <= '0;
		band_two    <= '0;
		band_three  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty statistics after reset give zero
		send_pixel(mfs_pkg::MODE_EMIT, 1'b0, 8'd200, 8'd100, 8'd50, 8'hFF);
		// all-zero frame: flat channels
		send_pixel(mfs_pkg::MODE_GATHER, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
		send_pixel(mfs_pkg::MODE_EMIT, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		// widen to the full product range
		send_pixel(mfs_pkg::MODE_GATHER, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(mfs_pkg::MODE_EMIT, 1'b0, 8'hFF, 8'hFF, 8'h00, 8'd128);
		send_pixel(mfs_pkg::MODE_EMIT, 1'b1, 8'd1, 8'd1, 8'd2, 8'd3);
		send_pixel(mfs_pkg::MODE_EMIT, 1'b0, 8'h00, 8'h55, 8'hAA, 8'hFF);
		// a single pixel after a clear sets both min and max
		send_pixel(mfs_pkg::MODE_GATHER, 1'b1, 8'd100, 8'd100, 8'd20, 8'd1);
		send_pixel(mfs_pkg::MODE_EMIT, 1'b0, 8'd100, 8'd100, 8'd20, 8'd1);
		send_pixel(mfs_pkg::MODE_EMIT, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		// proper range, then below, inside and above it
		send_pixel(mfs_pkg::MODE_GATHER, 1'b0, 8'd16, 8'd16, 8'd16, 8'd16);
		send_pixel(mfs_pkg::MODE_GATHER, 1'b0, 8'd200, 8'd200, 8'd200, 8'd200);
		send_pixel(mfs_pkg::MODE_EMIT, 1'b0, 8'd1, 8'd1, 8'h00, 8'd10);
		send_pixel(mfs_pkg::MODE_EMIT, 1'b0, 8'd100, 8'd100, 8'd150, 8'd77);
		send_pixel(mfs_pkg::MODE_EMIT, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'd250);
		// bit patterns on every field
		send_pixel(mfs_pkg::MODE_GATHER, 1'b1, 8'h55, 8'hAA, 8'h55, 8'hAA);
		send_pixel(mfs_pkg::MODE_GATHER, 1'b0, 8'hAA, 8'h55, 8'hAA, 8'h55);
		send_pixel(mfs_pkg::MODE_EMIT, 1'b1, 8'hAA, 8'hAA, 8'h55, 8'h80);
		send_pixel(mfs_pkg::MODE_EMIT, 1'b0, 8'h7F, 8'h7F, 8'h80, 8'h01);
		// emit with frame_start leaves the statistics alone
		send_pixel(mfs_pkg::MODE_EMIT, 1'b1, 8'h55, 8'hAA, 8'h55, 8'hAA);

		// random frames, the first one with a full drain before the emit pass
		run_frame(1'b1);
		while (words_sent < 1350)
			run_frame(1'b0);

		steady = 1'b0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// hard limit on the run
	initial begin
		#10000000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
src/mfs_pkg.sv
src/mfs_datapath.sv
src/mfs_ctrl.sv
src/multiplicative_fusion_stretch.sv
test/tb_top.sv
